// ===== hdl/per_cpu_page_allocator_with_steal_top_macros.svh =====
// ----------------------------------------------------------------------------
// Page allocator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PER_CPU_PAGE_ALLOCATOR_WITH_STEAL_TOP_MACROS_SVH
`define PER_CPU_PAGE_ALLOCATOR_WITH_STEAL_TOP_MACROS_SVH

// Condition must hold at every clock edge.
`define PCPA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PCPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Page allocator package
// Sizes, codes, shared types and helper functions of the page allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

  localparam int NUM_CPUS   = 8;
  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W    = 32;
  localparam int CPU_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam int CPU_IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int PG_W      = $clog2(NUM_PAGES);
  localparam int PB_W      = $clog2(PAGE_BYTES);
  localparam int APG_W     = ADDR_W - PB_W;
  localparam int BPG_W     = APG_W + 1;
  localparam int CNT_W     = $clog2(NUM_PAGES + 1);

  localparam logic [ADDR_W-1:0] POOL_START_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] POOL_STOP_RST  = 32'h8800_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_STOP  = 1'b1;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } pcpa_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_OOM      = 2'd1,
    STS_BAD_FREE = 2'd2
  } pcpa_status_e;

  // One entry of the next-link memory.
  typedef struct packed {
    logic            ok;
    logic [PG_W-1:0] pg;
  } pcpa_link_t;

  localparam int LINK_W = $bits(pcpa_link_t);

  // Pool settings as seen by the sequencer.
  typedef struct packed {
    logic [BPG_W-1:0]  bpage;
    logic [ADDR_W-1:0] stop;
  } pcpa_cfg_t;

  // Finished result handed to the output register.
  typedef struct packed {
    logic            valid;
    pcpa_status_e    status;
    logic            addr_en;
    logic [PG_W-1:0] pg;
  } pcpa_res_t;

  // CPU index taken modulo NUM_CPUS.
  function automatic logic [CPU_IDX_W-1:0] cpu_wrap(input logic [CPU_W-1:0] v);
    logic [CPU_W+1:0] r;
    r = {2'b00, v};
    for (int i = 0; i < (2 ** CPU_W); i++) begin
      if (r >= (CPU_W + 2)'(NUM_CPUS)) begin
        r = r - (CPU_W + 2)'(NUM_CPUS);
      end
    end
    return CPU_IDX_W'(r);
  endfunction

  // First managed page number: pool start rounded up to a page boundary.
  function automatic logic [BPG_W-1:0] base_page(input logic [ADDR_W-1:0] start);
    return {1'b0, start[ADDR_W-1:PB_W]} + BPG_W'(|start[PB_W-1:0]);
  endfunction

endpackage

// ===== hdl/pcpa_if.sv =====
// ----------------------------------------------------------------------------
// Page allocator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcpa_req_if
  import pcpa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [CPU_W-1:0]  cpu;
  logic [ADDR_W-1:0] free_addr;

  modport source (output valid, cmd, cpu, free_addr, input ready);
  modport sink   (input valid, cmd, cpu, free_addr, output ready);
endinterface

interface pcpa_rsp_if
  import pcpa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   page_addr;

  modport source (output valid, status, page_addr, input ready);
  modport sink   (input valid, status, page_addr, output ready);
endinterface

// ===== hdl/pcpa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/pcpa_seq.sv =====
// ----------------------------------------------------------------------------
// Page allocator sequencer
// Holds the per-CPU list heads and runs push, pop and steal walks over the
// shared next-link memory port.
// ----------------------------------------------------------------------------
`include "per_cpu_page_allocator_with_steal_top_macros.svh"

module pcpa_seq
  import pcpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  pcpa_req_if.sink          req_i,
  input  pcpa_cfg_t         cfg_i,
  output pcpa_res_t         res_o,
  input  logic              res_ready_i,
  output logic              ram_we_o,
  output logic [PG_W-1:0]   ram_waddr_o,
  output pcpa_link_t        ram_wdata_o,
  output logic [PG_W-1:0]   ram_raddr_o,
  input  pcpa_link_t        ram_rdata_i
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DISP     = 11'b000_0000_0010,
    S_FREE     = 11'b000_0000_0100,
    S_POP      = 11'b000_0000_1000,
    S_GOT_H    = 11'b000_0001_0000,
    S_GOT_FAST = 11'b000_0010_0000,
    S_GOT_SLOW = 11'b000_0100_0000,
    S_GOT_TMP  = 11'b000_1000_0000,
    S_RD_SLOW  = 11'b001_0000_0000,
    S_CUT      = 11'b010_0000_0000,
    S_EMIT     = 11'b100_0000_0000
  } pcpa_state_e;

  pcpa_state_e state_q, state_d;

  logic                 cmd_q, cmd_d;
  logic [CPU_IDX_W-1:0] cpu_q, cpu_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [PG_W-1:0]      head_q [NUM_CPUS];
  logic [PG_W-1:0]      head_d [NUM_CPUS];
  logic [NUM_CPUS-1:0]  hok_q, hok_d;
  logic [CPU_IDX_W-1:0] vic_q, vic_d;
  logic [PG_W-1:0]      h_q, h_d;
  logic [PG_W-1:0]      slow_q, slow_d;
  logic [PG_W-1:0]      tmp_q, tmp_d;
  logic [PG_W-1:0]      hnext_q, hnext_d;
  logic                 hnok_q, hnok_d;
  logic [CNT_W-1:0]     k_q, k_d;
  pcpa_status_e         sts_q, sts_d;
  logic                 aen_q, aen_d;
  logic [PG_W-1:0]      rpg_q, rpg_d;

  logic                 vic_found;
  logic [CPU_IDX_W-1:0] vic_sel;
  logic [APG_W-1:0]     apage;
  logic [BPG_W-1:0]     diff;
  logic                 free_ok;
  logic [CNT_W-1:0]     k_inc;

  // First other CPU with a non-empty list, in index order.
  always_comb begin
    vic_found = 1'b0;
    vic_sel   = '0;
    for (int j = 0; j < NUM_CPUS; j++) begin
      if (!vic_found && (CPU_IDX_W'(j) != cpu_q) && hok_q[j]) begin
        vic_found = 1'b1;
        vic_sel   = CPU_IDX_W'(j);
      end
    end
  end

  // Free address check against the pool window.
  assign apage   = addr_q[ADDR_W-1:PB_W];
  assign diff    = {1'b0, apage} - cfg_i.bpage;
  assign free_ok = (addr_q[PB_W-1:0] == '0) && ({1'b0, apage} >= cfg_i.bpage) &&
                   (addr_q < cfg_i.stop) && (diff < BPG_W'(NUM_PAGES));
  assign k_inc   = k_q + CNT_W'(1);

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    cpu_d   = cpu_q;
    addr_d  = addr_q;
    head_d  = head_q;
    hok_d   = hok_q;
    vic_d   = vic_q;
    h_d     = h_q;
    slow_d  = slow_q;
    tmp_d   = tmp_q;
    hnext_d = hnext_q;
    hnok_d  = hnok_q;
    k_d     = k_q;
    sts_d   = sts_q;
    aen_d   = aen_q;
    rpg_d   = rpg_q;

    req_i.ready  = 1'b0;
    ram_we_o     = 1'b0;
    ram_waddr_o  = slow_q;
    ram_wdata_o  = '0;
    ram_raddr_o  = slow_q;
    res_o        = '0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          cmd_d   = req_i.cmd;
          cpu_d   = cpu_wrap(req_i.cpu);
          addr_d  = req_i.free_addr;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        sts_d = STS_OK;
        aen_d = 1'b0;
        rpg_d = '0;
        if (cmd_q == CMD_FREE) begin
          state_d = S_FREE;
        end else if (hok_q[cpu_q]) begin
          h_d         = head_q[cpu_q];
          ram_raddr_o = head_q[cpu_q];
          state_d     = S_POP;
        end else if (vic_found) begin
          vic_d       = vic_sel;
          h_d         = head_q[vic_sel];
          slow_d      = head_q[vic_sel];
          ram_raddr_o = head_q[vic_sel];
          k_d         = '0;
          state_d     = S_GOT_H;
        end else begin
          sts_d   = STS_OOM;
          state_d = S_EMIT;
        end
      end
      S_FREE: begin
        if (free_ok) begin
          ram_we_o       = 1'b1;
          ram_waddr_o    = diff[PG_W-1:0];
          ram_wdata_o.ok = hok_q[cpu_q];
          ram_wdata_o.pg = head_q[cpu_q];
          head_d[cpu_q]  = diff[PG_W-1:0];
          hok_d[cpu_q]   = 1'b1;
        end else begin
          sts_d = STS_BAD_FREE;
        end
        state_d = S_EMIT;
      end
      S_POP: begin
        head_d[cpu_q] = ram_rdata_i.ok ? ram_rdata_i.pg : '0;
        hok_d[cpu_q]  = ram_rdata_i.ok;
        aen_d         = 1'b1;
        rpg_d         = h_q;
        state_d       = S_EMIT;
      end
      S_GOT_H: begin
        hnext_d = ram_rdata_i.pg;
        hnok_d  = ram_rdata_i.ok;
        if (ram_rdata_i.ok) begin
          ram_raddr_o = ram_rdata_i.pg;
          state_d     = S_GOT_FAST;
        end else begin
          state_d = S_RD_SLOW;
        end
      end
      S_GOT_FAST: begin
        if (ram_rdata_i.ok) begin
          tmp_d       = ram_rdata_i.pg;
          ram_raddr_o = slow_q;
          state_d     = S_GOT_SLOW;
        end else begin
          state_d = S_RD_SLOW;
        end
      end
      S_GOT_SLOW: begin
        slow_d      = ram_rdata_i.ok ? ram_rdata_i.pg : '0;
        ram_raddr_o = tmp_q;
        state_d     = S_GOT_TMP;
      end
      S_GOT_TMP: begin
        k_d = k_inc;
        if (ram_rdata_i.ok && (k_inc != CNT_W'(NUM_PAGES))) begin
          ram_raddr_o = ram_rdata_i.pg;
          state_d     = S_GOT_FAST;
        end else begin
          state_d = S_RD_SLOW;
        end
      end
      S_RD_SLOW: begin
        ram_raddr_o = slow_q;
        state_d     = S_CUT;
      end
      S_CUT: begin
        // The victim keeps what follows the middle page.
        head_d[vic_q] = ram_rdata_i.ok ? ram_rdata_i.pg : '0;
        hok_d[vic_q]  = ram_rdata_i.ok;
        ram_we_o      = 1'b1;
        ram_waddr_o   = slow_q;
        // When the middle is the head itself the stolen part is one page.
        if (slow_q == h_q) begin
          head_d[cpu_q] = '0;
          hok_d[cpu_q]  = 1'b0;
        end else begin
          head_d[cpu_q] = hnext_q;
          hok_d[cpu_q]  = hnok_q;
        end
        aen_d   = 1'b1;
        rpg_d   = h_q;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        res_o.valid   = 1'b1;
        res_o.status  = sts_q;
        res_o.addr_en = aen_q;
        res_o.pg      = rpg_q;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hok_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      hok_q   <= hok_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    cpu_q   <= cpu_d;
    addr_q  <= addr_d;
    head_q  <= head_d;
    vic_q   <= vic_d;
    h_q     <= h_d;
    slow_q  <= slow_d;
    tmp_q   <= tmp_d;
    hnext_q <= hnext_d;
    hnok_q  <= hnok_d;
    sts_q   <= sts_d;
    aen_q   <= aen_d;
    rpg_q   <= rpg_d;
  end

  `PCPA_ASSERT_IMP(a_wr_state, ram_we_o, (state_q == S_FREE) || (state_q == S_CUT), "link write outside push or cut")
  `PCPA_ASSERT_NXT(a_acc_disp, req_i.valid && req_i.ready, state_q == S_DISP, "accepted request not dispatched")
  `PCPA_ASSERT_ALWAYS(a_walk_bound, k_q <= CNT_W'(NUM_PAGES), "walk counter past page count")
  `PCPA_ASSERT_NXT(a_one_page, (state_q == S_CUT) && (slow_q == h_q), !hok_q[cpu_q], "single stolen page left on requester list")

endmodule

// ===== hdl/per_cpu_page_allocator_with_steal_top.sv =====
// ----------------------------------------------------------------------------
// Per-CPU page allocator with steal
// Per-CPU LIFO free lists of physical pages with work stealing on allocate.
// ----------------------------------------------------------------------------
// Usage: a requester sends one item per transfer on req_i: cmd selects
// allocate or free, cpu names the requesting CPU and free_addr carries the
// page address to free. Every request yields exactly one transfer on rsp_o
// with a status code and, for a successful allocate, the page address.
// The pool window is set through the write port cfg_*: index 0 is the pool
// start (rounded up to a page boundary), index 1 the exclusive pool end.
// The user must make writes only while no request is in flight; the block itself does not enforce this.
// A new request is accepted only after the result of the last one has
// been handed to the output register. A steal walks the victim list
// with one read of the single next-link memory port per cycle, three
// reads per step of the middle search.
// Reset empties every list at once; the link memory is never cleared since
// an entry is only read after it has been written.
// A stalled receiver holds the result in the output register; the block
// finishes the next request and then waits until that register drains.
// ----------------------------------------------------------------------------
module per_cpu_page_allocator_with_steal_top
  import pcpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pcpa_req_if.sink             req_i,
  pcpa_rsp_if.source           rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i
);

  // Pool window registers.
  logic [ADDR_W-1:0] pool_start_q, pool_start_d;
  logic [ADDR_W-1:0] pool_stop_q, pool_stop_d;

  // First managed page number, registered from the pool start each cycle.
  // The sequencer reads it only in states after dispatch, so a write just
  // before a request is always seen.
  logic [BPG_W-1:0] bpage_q;

  pcpa_cfg_t  cfg;
  pcpa_res_t  res;
  logic       res_ready;

  logic       ram_we;
  logic [PG_W-1:0] ram_waddr;
  logic [PG_W-1:0] ram_raddr;
  pcpa_link_t ram_wdata;
  pcpa_link_t ram_rdata;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [APG_W-1:0]    res_apage;

  always_comb begin
    pool_start_d = pool_start_q;
    pool_stop_d  = pool_stop_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POOL_START: pool_start_d = cfg_wdata_i;
        CFG_POOL_STOP:  pool_stop_d  = cfg_wdata_i;
        default: begin
          pool_start_d = pool_start_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_start_q <= POOL_START_RST;
      pool_stop_q  <= POOL_STOP_RST;
    end else begin
      pool_start_q <= pool_start_d;
      pool_stop_q  <= pool_stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bpage_q <= base_page(pool_start_q);
  end

  assign cfg.bpage = bpage_q;
  assign cfg.stop  = pool_stop_q;

  pcpa_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_i       (cfg),
    .res_o       (res),
    .res_ready_i (res_ready),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  pcpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Page address follows the current base; it wraps at 32 bits.
  assign res_apage = APG_W'(bpage_q + BPG_W'(res.pg));
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_status_q <= res.status;
      out_addr_q   <= res.addr_en ? {res_apage, {PB_W{1'b0}}} : '0;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.page_addr = out_addr_q;

endmodule
